FILE: hdl/assert_macros.svh
// Assertion macros shared by the plane intersection RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPI_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("%m: check failed");
`define PPI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define PPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define PPI_ASSERT(lbl, clk, rstn, expr)
`define PPI_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/ppi_pkg.sv
// Types, constants and helper functions for the plane intersection unit.
// No dependencies; used by every module of the block.
package ppi_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int EPS_WIDTH     = 31;
    localparam int PROD_WIDTH    = 2 * COORD_WIDTH;
    localparam int WIDE_WIDTH    = 2 * COORD_WIDTH + 3;
    localparam int ABS_SUM_WIDTH = COORD_WIDTH + 2;
    localparam int CMP_WIDTH     = (ABS_SUM_WIDTH > EPS_WIDTH) ? ABS_SUM_WIDTH : EPS_WIDTH;
    localparam int DIV_STAGES    = PROD_WIDTH;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [COORD_WIDTH-1:0] mag_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic        [PROD_WIDTH-1:0]  pmag_t;
    typedef logic signed [PROD_WIDTH:0]    cprod_t;
    typedef logic signed [COORD_WIDTH:0]   cdiff_t;
    typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
    typedef logic        [EPS_WIDTH-1:0]   eps_t;
    typedef logic        [1:0]             rel_t;
    typedef logic        [1:0]             axis_t;

    localparam eps_t EPS_RESET = EPS_WIDTH'(66);

    localparam rel_t REL_DISJOINT = 2'd0;
    localparam rel_t REL_COINCIDE = 2'd1;
    localparam rel_t REL_LINE     = 2'd2;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        coord_t na_x, na_y, na_z;
        coord_t ca_x, ca_y, ca_z;
        coord_t nb_x, nb_y, nb_z;
        coord_t cb_x, cb_y, cb_z;
    } in_item_t;

    // lane 0 solves db*x0 - da*y0, lane 1 the negated db*x1 - da*y1
    typedef struct packed {
        rel_t   relation;
        coord_t dir_x, dir_y, dir_z;
        axis_t  axis;
        coord_t divisor;
        coord_t da, db;
        coord_t x0, y0, x1, y1;
    } qentry_t;

    typedef struct packed {
        logic    push;
        qentry_t data;
    } qpush_t;

    typedef struct packed {
        rel_t   relation;
        coord_t dir_x, dir_y, dir_z;
        axis_t  axis;
        logic   neg0, neg1;
        logic   zero_div;
    } side_t;

    function automatic coord_t shift_sat(input wide_t v);
        wide_t                          s;
        logic [WIDE_WIDTH-COORD_WIDTH:0] hi;
        coord_t                         r;
        s  = v >>> FRAC_BITS;
        hi = s[WIDE_WIDTH-1:COORD_WIDTH-1];
        if (hi == '0 || hi == '1)
        begin
            r = s[COORD_WIDTH-1:0];
        end
        else
        begin
            r = s[WIDE_WIDTH-1] ? COORD_MIN : COORD_MAX;
        end
        return r;
    endfunction

    function automatic mag_t abs_mag(input coord_t v);
        return v[COORD_WIDTH-1] ? (~mag_t'(v) + mag_t'(1)) : mag_t'(v);
    endfunction

    function automatic pmag_t abs_pmag(input prod_t v);
        return v[PROD_WIDTH-1] ? (~pmag_t'(v) + pmag_t'(1)) : pmag_t'(v);
    endfunction

endpackage

FILE: hdl/ppi_front.sv
// Front pipeline: products, direction, plane constants and classification.
// Depends on ppi_pkg; pushes one entry per request into ppi_queue.
module ppi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ppi_pkg::in_item_t item,
    input  ppi_pkg::eps_t     eps,
    input  logic              q_full,
    output ppi_pkg::qpush_t   qp
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg;

    ppi_pkg::coord_t na[3], ca[3], nb[3], cb[3];
    ppi_pkg::prod_t  cr_next[6];
    ppi_pkg::prod_t  pa_next[3], pb_next[3];
    ppi_pkg::cprod_t pc_next[3];
    ppi_pkg::cdiff_t dc[3];

    ppi_pkg::prod_t  cr_reg[6];
    ppi_pkg::prod_t  pa_reg[3], pb_reg[3];
    ppi_pkg::cprod_t pc_reg[3];
    ppi_pkg::coord_t na1_reg[3], nb1_reg[3];

    ppi_pkg::coord_t u_next[3], u_reg[3];
    ppi_pkg::coord_t da_next, db_next, da_reg, db_reg;
    logic            dz_next, dz_reg;
    ppi_pkg::coord_t na2_reg[3], nb2_reg[3];

    ppi_pkg::mag_t                       ax, ay, az;
    logic [ppi_pkg::ABS_SUM_WIDTH-1:0]   asum;
    logic                                parallel;
    ppi_pkg::qentry_t                    e_next, e_reg;

    assign adv      = !(v3_reg && q_full);
    assign in_ready = adv;
    assign qp.push  = v3_reg && !q_full;
    assign qp.data  = e_reg;

    assign na = '{item.na_x, item.na_y, item.na_z};
    assign ca = '{item.ca_x, item.ca_y, item.ca_z};
    assign nb = '{item.nb_x, item.nb_y, item.nb_z};
    assign cb = '{item.cb_x, item.cb_y, item.cb_z};

    always_comb
    begin
        cr_next[0] = ppi_pkg::prod_t'(na[1]) * ppi_pkg::prod_t'(nb[2]);
        cr_next[1] = ppi_pkg::prod_t'(na[2]) * ppi_pkg::prod_t'(nb[1]);
        cr_next[2] = ppi_pkg::prod_t'(na[2]) * ppi_pkg::prod_t'(nb[0]);
        cr_next[3] = ppi_pkg::prod_t'(na[0]) * ppi_pkg::prod_t'(nb[2]);
        cr_next[4] = ppi_pkg::prod_t'(na[0]) * ppi_pkg::prod_t'(nb[1]);
        cr_next[5] = ppi_pkg::prod_t'(na[1]) * ppi_pkg::prod_t'(nb[0]);
        for (int i = 0; i < 3; i++)
        begin
            pa_next[i] = ppi_pkg::prod_t'(na[i]) * ppi_pkg::prod_t'(ca[i]);
            pb_next[i] = ppi_pkg::prod_t'(nb[i]) * ppi_pkg::prod_t'(cb[i]);
            dc[i]      = ppi_pkg::cdiff_t'(cb[i]) - ppi_pkg::cdiff_t'(ca[i]);
            pc_next[i] = ppi_pkg::cprod_t'(na[i]) * ppi_pkg::cprod_t'(dc[i]);
        end
    end

    always_comb
    begin
        u_next[0] = ppi_pkg::shift_sat(ppi_pkg::wide_t'(cr_reg[0]) - ppi_pkg::wide_t'(cr_reg[1]));
        u_next[1] = ppi_pkg::shift_sat(ppi_pkg::wide_t'(cr_reg[2]) - ppi_pkg::wide_t'(cr_reg[3]));
        u_next[2] = ppi_pkg::shift_sat(ppi_pkg::wide_t'(cr_reg[4]) - ppi_pkg::wide_t'(cr_reg[5]));
        da_next   = ppi_pkg::shift_sat(-(ppi_pkg::wide_t'(pa_reg[0]) + ppi_pkg::wide_t'(pa_reg[1])
                                         + ppi_pkg::wide_t'(pa_reg[2])));
        db_next   = ppi_pkg::shift_sat(-(ppi_pkg::wide_t'(pb_reg[0]) + ppi_pkg::wide_t'(pb_reg[1])
                                         + ppi_pkg::wide_t'(pb_reg[2])));
        dz_next   = (ppi_pkg::wide_t'(pc_reg[0]) + ppi_pkg::wide_t'(pc_reg[1])
                     + ppi_pkg::wide_t'(pc_reg[2])) == '0;
    end

    always_comb
    begin
        ax   = ppi_pkg::abs_mag(u_reg[0]);
        ay   = ppi_pkg::abs_mag(u_reg[1]);
        az   = ppi_pkg::abs_mag(u_reg[2]);
        asum = ppi_pkg::ABS_SUM_WIDTH'(ax) + ppi_pkg::ABS_SUM_WIDTH'(ay)
               + ppi_pkg::ABS_SUM_WIDTH'(az);
        parallel = ppi_pkg::CMP_WIDTH'(asum) < ppi_pkg::CMP_WIDTH'(eps);

        e_next       = '0;
        e_next.dir_x = u_reg[0];
        e_next.dir_y = u_reg[1];
        e_next.dir_z = u_reg[2];
        e_next.da    = da_reg;
        e_next.db    = db_reg;
        if (parallel)
        begin
            e_next.relation = dz_reg ? ppi_pkg::REL_COINCIDE : ppi_pkg::REL_DISJOINT;
        end
        else
        begin
            e_next.relation = ppi_pkg::REL_LINE;
        end

        if (ax > ay && ax > az)
        begin
            e_next.axis    = ppi_pkg::AXIS_X;
            e_next.divisor = u_reg[0];
            e_next.x0      = na2_reg[2];
            e_next.y0      = nb2_reg[2];
            e_next.x1      = na2_reg[1];
            e_next.y1      = nb2_reg[1];
        end
        else if (ax <= ay && ay > az)
        begin
            e_next.axis    = ppi_pkg::AXIS_Y;
            e_next.divisor = u_reg[1];
            e_next.x0      = na2_reg[0];
            e_next.y0      = nb2_reg[0];
            e_next.x1      = na2_reg[2];
            e_next.y1      = nb2_reg[2];
        end
        else
        begin
            e_next.axis    = ppi_pkg::AXIS_Z;
            e_next.divisor = u_reg[2];
            e_next.x0      = na2_reg[1];
            e_next.y0      = nb2_reg[1];
            e_next.x1      = na2_reg[0];
            e_next.y1      = nb2_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cr_reg  <= cr_next;
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            pc_reg  <= pc_next;
            na1_reg <= na;
            nb1_reg <= nb;
            u_reg   <= u_next;
            da_reg  <= da_next;
            db_reg  <= db_next;
            dz_reg  <= dz_next;
            na2_reg <= na1_reg;
            nb2_reg <= nb1_reg;
            e_reg   <= e_next;
        end
    end

endmodule

FILE: hdl/ppi_queue.sv
// Short request queue between the front and back pipelines.
// Depends on ppi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppi_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  ppi_pkg::qpush_t  qp,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output ppi_pkg::qentry_t head
);

    ppi_pkg::qentry_t                mem_reg[ppi_pkg::QUEUE_DEPTH];
    logic [ppi_pkg::QPTR_WIDTH-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [ppi_pkg::QPTR_WIDTH:0]    count_reg;

    assign full       = count_reg == (ppi_pkg::QPTR_WIDTH+1)'(ppi_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    function automatic logic [ppi_pkg::QPTR_WIDTH-1:0] ptr_inc(
        input logic [ppi_pkg::QPTR_WIDTH-1:0] p);
        return (p == ppi_pkg::QPTR_WIDTH'(ppi_pkg::QUEUE_DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (qp.push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (qp.push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !qp.push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (qp.push)
        begin
            mem_reg[wr_ptr_reg] <= qp.data;
        end
    end

    `PPI_ASSERT_IMPL(a_no_overflow, clk, rst_n, qp.push, !full)
    `PPI_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head_valid)
    `PPI_ASSERT(a_count_bound, clk, rst_n,
        count_reg <= (ppi_pkg::QPTR_WIDTH+1)'(ppi_pkg::QUEUE_DEPTH))

endmodule

FILE: hdl/ppi_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on ppi_pkg; instantiated twice by ppi_back.
module ppi_div (
    input  logic          clk,
    input  logic          en,
    input  ppi_pkg::pmag_t num,
    input  ppi_pkg::mag_t  den,
    output ppi_pkg::pmag_t quo
);

    ppi_pkg::mag_t  rem_reg[ppi_pkg::DIV_STAGES];
    ppi_pkg::pmag_t nq_reg[ppi_pkg::DIV_STAGES];
    ppi_pkg::mag_t  den_reg[ppi_pkg::DIV_STAGES];

    for (genvar s = 0; s < ppi_pkg::DIV_STAGES; s++)
    begin : g_stage
        ppi_pkg::mag_t               rem_in, den_in, rem_next;
        ppi_pkg::pmag_t              nq_in, nq_next;
        logic [ppi_pkg::COORD_WIDTH:0] t;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        always_comb
        begin
            t = {rem_in, nq_in[ppi_pkg::PROD_WIDTH-1]};
            if (t >= {1'b0, den_in})
            begin
                rem_next = ppi_pkg::mag_t'(t - {1'b0, den_in});
                nq_next  = {nq_in[ppi_pkg::PROD_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = t[ppi_pkg::COORD_WIDTH-1:0];
                nq_next  = {nq_in[ppi_pkg::PROD_WIDTH-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                nq_reg[s]  <= nq_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = nq_reg[ppi_pkg::DIV_STAGES-1];

endmodule

FILE: hdl/ppi_back.sv
// Back pipeline: numerators, two pipelined dividers, saturation, output register.
// Depends on ppi_pkg, ppi_div and assert_macros.svh.
`include "assert_macros.svh"

module ppi_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  ppi_pkg::qentry_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output ppi_pkg::rel_t    relation,
    output ppi_pkg::coord_t  line_dir_x,
    output ppi_pkg::coord_t  line_dir_y,
    output ppi_pkg::coord_t  line_dir_z,
    output ppi_pkg::coord_t  line_point_x,
    output ppi_pkg::coord_t  line_point_y,
    output ppi_pkg::coord_t  line_point_z
);

    localparam int LAST = ppi_pkg::DIV_STAGES - 1;

    logic adv;
    logic v1_reg, v2_reg, out_valid_reg;
    logic vd_reg[ppi_pkg::DIV_STAGES];

    ppi_pkg::qentry_t e1_reg;
    ppi_pkg::prod_t   mdb0_reg, mda0_reg, mdb1_reg, mda1_reg;

    ppi_pkg::prod_t   num0, num1;
    ppi_pkg::side_t   side2_next, side2_reg;
    ppi_pkg::side_t   sd_reg[ppi_pkg::DIV_STAGES];
    ppi_pkg::pmag_t   mag0_reg, mag1_reg, quo0, quo1;
    ppi_pkg::mag_t    den_reg;

    ppi_pkg::side_t   sl;
    ppi_pkg::coord_t  q0, q1;
    ppi_pkg::coord_t  px_next, py_next, pz_next;
    ppi_pkg::rel_t    rel_reg;
    ppi_pkg::coord_t  dx_reg, dy_reg, dz_reg, px_reg, py_reg, pz_reg;

    assign adv = !out_valid_reg || out_ready;
    assign pop = head_valid && adv;

    assign num0 = mdb0_reg - mda0_reg;
    assign num1 = mdb1_reg - mda1_reg;

    always_comb
    begin
        side2_next.relation = e1_reg.relation;
        side2_next.dir_x    = e1_reg.dir_x;
        side2_next.dir_y    = e1_reg.dir_y;
        side2_next.dir_z    = e1_reg.dir_z;
        side2_next.axis     = e1_reg.axis;
        side2_next.neg0     = num0[ppi_pkg::PROD_WIDTH-1]
                              ^ e1_reg.divisor[ppi_pkg::COORD_WIDTH-1];
        side2_next.neg1     = ~(num1[ppi_pkg::PROD_WIDTH-1]
                              ^ e1_reg.divisor[ppi_pkg::COORD_WIDTH-1]);
        side2_next.zero_div = e1_reg.divisor == '0;
    end

    ppi_div u_div0 (
        .clk (clk),
        .en  (adv),
        .num (mag0_reg),
        .den (den_reg),
        .quo (quo0)
    );

    ppi_div u_div1 (
        .clk (clk),
        .en  (adv),
        .num (mag1_reg),
        .den (den_reg),
        .quo (quo1)
    );

    function automatic ppi_pkg::coord_t quo_sat(input ppi_pkg::pmag_t q, input logic neg);
        ppi_pkg::coord_t r;
        if (neg)
        begin
            if (q[ppi_pkg::PROD_WIDTH-1:ppi_pkg::COORD_WIDTH] != '0
                || (q[ppi_pkg::COORD_WIDTH-1] && q[ppi_pkg::COORD_WIDTH-2:0] != '0))
            begin
                r = ppi_pkg::COORD_MIN;
            end
            else
            begin
                r = ppi_pkg::coord_t'(~q[ppi_pkg::COORD_WIDTH-1:0] + 1'b1);
            end
        end
        else
        begin
            if (q[ppi_pkg::PROD_WIDTH-1:ppi_pkg::COORD_WIDTH-1] != '0)
            begin
                r = ppi_pkg::COORD_MAX;
            end
            else
            begin
                r = ppi_pkg::coord_t'(q[ppi_pkg::COORD_WIDTH-1:0]);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        sl      = sd_reg[LAST];
        q0      = quo_sat(quo0, sl.neg0);
        q1      = quo_sat(quo1, sl.neg1);
        px_next = '0;
        py_next = '0;
        pz_next = '0;
        if (sl.relation == ppi_pkg::REL_LINE && !sl.zero_div)
        begin
            unique case (sl.axis)
                ppi_pkg::AXIS_X:
                begin
                    py_next = q0;
                    pz_next = q1;
                end
                ppi_pkg::AXIS_Y:
                begin
                    px_next = q1;
                    pz_next = q0;
                end
                default:
                begin
                    px_next = q0;
                    py_next = q1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < ppi_pkg::DIV_STAGES; s++)
            begin
                vd_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= head_valid;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int s = 1; s < ppi_pkg::DIV_STAGES; s++)
            begin
                vd_reg[s] <= vd_reg[s-1];
            end
            out_valid_reg <= vd_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg    <= head;
            mdb0_reg  <= ppi_pkg::prod_t'(head.db) * ppi_pkg::prod_t'(head.x0);
            mda0_reg  <= ppi_pkg::prod_t'(head.da) * ppi_pkg::prod_t'(head.y0);
            mdb1_reg  <= ppi_pkg::prod_t'(head.db) * ppi_pkg::prod_t'(head.x1);
            mda1_reg  <= ppi_pkg::prod_t'(head.da) * ppi_pkg::prod_t'(head.y1);
            side2_reg <= side2_next;
            mag0_reg  <= ppi_pkg::abs_pmag(num0);
            mag1_reg  <= ppi_pkg::abs_pmag(num1);
            den_reg   <= ppi_pkg::abs_mag(e1_reg.divisor);
            sd_reg[0] <= side2_reg;
            for (int s = 1; s < ppi_pkg::DIV_STAGES; s++)
            begin
                sd_reg[s] <= sd_reg[s-1];
            end
            rel_reg <= sl.relation;
            dx_reg  <= sl.dir_x;
            dy_reg  <= sl.dir_y;
            dz_reg  <= sl.dir_z;
            px_reg  <= px_next;
            py_reg  <= py_next;
            pz_reg  <= pz_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign relation     = rel_reg;
    assign line_dir_x   = dx_reg;
    assign line_dir_y   = dy_reg;
    assign line_dir_z   = dz_reg;
    assign line_point_x = px_reg;
    assign line_point_y = py_reg;
    assign line_point_z = pz_reg;

    `PPI_ASSERT_NEXT(a_pop_fills_stage, clk, rst_n, pop, v1_reg)
    `PPI_ASSERT_IMPL(a_no_line_zero_point, clk, rst_n,
        out_valid_reg && rel_reg != ppi_pkg::REL_LINE,
        px_reg == '0 && py_reg == '0 && pz_reg == '0)

endmodule

FILE: hdl/plane_plane_intersection_unit.sv
// Top level of the plane-plane intersection unit.
// Depends on ppi_pkg, ppi_front, ppi_queue and ppi_back.
//
// Takes one plane pair per cycle unless the full queue stalls the front,
// and returns one result per pair, in order. A pair passes three front stages
// (products, sums, classification), one queue stage, two numerator stages, 64
// divider stages (one quotient bit per stage in two parallel dividers) and the
// output register. The pipelined dividers set both the latency and the depth;
// the four-entry queue lets the front keep accepting while the output stalls, until it fills.
module plane_plane_intersection_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ppi_pkg::coord_t normal_a_x,
    input  ppi_pkg::coord_t normal_a_y,
    input  ppi_pkg::coord_t normal_a_z,
    input  ppi_pkg::coord_t center_a_x,
    input  ppi_pkg::coord_t center_a_y,
    input  ppi_pkg::coord_t center_a_z,
    input  ppi_pkg::coord_t normal_b_x,
    input  ppi_pkg::coord_t normal_b_y,
    input  ppi_pkg::coord_t normal_b_z,
    input  ppi_pkg::coord_t center_b_x,
    input  ppi_pkg::coord_t center_b_y,
    input  ppi_pkg::coord_t center_b_z,
    output logic            out_valid,
    input  logic            out_ready,
    output ppi_pkg::rel_t   relation,
    output ppi_pkg::coord_t line_dir_x,
    output ppi_pkg::coord_t line_dir_y,
    output ppi_pkg::coord_t line_dir_z,
    output ppi_pkg::coord_t line_point_x,
    output ppi_pkg::coord_t line_point_y,
    output ppi_pkg::coord_t line_point_z,
    input  logic            cfg_wr_en,
    input  ppi_pkg::eps_t   cfg_wr_data
);

    ppi_pkg::eps_t    eps_reg;
    ppi_pkg::in_item_t item;
    ppi_pkg::qpush_t  qp;
    ppi_pkg::qentry_t head;
    logic             q_full, head_valid, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= ppi_pkg::EPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            eps_reg <= cfg_wr_data;
        end
    end

    assign item = '{na_x: normal_a_x, na_y: normal_a_y, na_z: normal_a_z,
                    ca_x: center_a_x, ca_y: center_a_y, ca_z: center_a_z,
                    nb_x: normal_b_x, nb_y: normal_b_y, nb_z: normal_b_z,
                    cb_x: center_b_x, cb_y: center_b_y, cb_z: center_b_z};

    ppi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .item     (item),
        .eps      (eps_reg),
        .q_full   (q_full),
        .qp       (qp)
    );

    ppi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .qp         (qp),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ppi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .relation     (relation),
        .line_dir_x   (line_dir_x),
        .line_dir_y   (line_dir_y),
        .line_dir_z   (line_dir_z),
        .line_point_x (line_point_x),
        .line_point_y (line_point_y),
        .line_point_z (line_point_z)
    );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for plane_plane_intersection_unit.
// Depends on ppi_pkg and the unit's RTL; predicts every result in-line and
// compares it with the output stream, under random gaps and stalls.
module tb_top;
    import ppi_pkg::*;

    typedef logic signed [129:0] big_t;

    typedef struct {
        rel_t   rel;
        coord_t dir [3];
        coord_t pt  [3];
    } line_res_t;

    class line_scoreboard;
        line_res_t expected_lines[$];
        longint    eps_val;
        int        mismatches;

        function new();
            eps_val    = 66;
            mismatches = 0;
        endfunction

        function automatic coord_t clamp(big_t v);
            if (v > big_t'(COORD_MAX))
            begin
                return COORD_MAX;
            end
            if (v < big_t'(COORD_MIN))
            begin
                return COORD_MIN;
            end
            return v[COORD_WIDTH-1:0];
        endfunction

        function automatic big_t mul(coord_t a, coord_t b);
            return big_t'(a) * big_t'(b);
        endfunction

        function automatic coord_t quot(big_t n, coord_t d);
            if (d == 0)
            begin
                return '0;
            end
            return clamp(n / big_t'(d));
        endfunction

        function automatic big_t mag(coord_t v);
            return (v < 0) ? -big_t'(v) : big_t'(v);
        endfunction

        function void note_request(in_item_t it);
            line_res_t r;
            big_t      ax, ay, az, dot;
            coord_t    da, db;
            r.dir[0] = clamp((mul(it.na_y, it.nb_z) - mul(it.na_z, it.nb_y)) >>> FRAC_BITS);
            r.dir[1] = clamp((mul(it.na_z, it.nb_x) - mul(it.na_x, it.nb_z)) >>> FRAC_BITS);
            r.dir[2] = clamp((mul(it.na_x, it.nb_y) - mul(it.na_y, it.nb_x)) >>> FRAC_BITS);
            r.pt[0] = '0;
            r.pt[1] = '0;
            r.pt[2] = '0;
            ax = mag(r.dir[0]);
            ay = mag(r.dir[1]);
            az = mag(r.dir[2]);
            if (ax + ay + az < big_t'(eps_val))
            begin
                dot = big_t'(it.na_x) * (big_t'(it.cb_x) - big_t'(it.ca_x))
                    + big_t'(it.na_y) * (big_t'(it.cb_y) - big_t'(it.ca_y))
                    + big_t'(it.na_z) * (big_t'(it.cb_z) - big_t'(it.ca_z));
                r.rel = (dot == 0) ? REL_COINCIDE : REL_DISJOINT;
            end
            else
            begin
                r.rel = REL_LINE;
                da = clamp((-(mul(it.na_x, it.ca_x) + mul(it.na_y, it.ca_y)
                    + mul(it.na_z, it.ca_z))) >>> FRAC_BITS);
                db = clamp((-(mul(it.nb_x, it.cb_x) + mul(it.nb_y, it.cb_y)
                    + mul(it.nb_z, it.cb_z))) >>> FRAC_BITS);
                if (ax > ay && ax > az)
                begin
                    r.pt[1] = quot(mul(db, it.na_z) - mul(da, it.nb_z), r.dir[0]);
                    r.pt[2] = quot(mul(da, it.nb_y) - mul(db, it.na_y), r.dir[0]);
                end
                else if (ax <= ay && ay > az)
                begin
                    r.pt[0] = quot(mul(da, it.nb_z) - mul(db, it.na_z), r.dir[1]);
                    r.pt[2] = quot(mul(db, it.na_x) - mul(da, it.nb_x), r.dir[1]);
                end
                else
                begin
                    r.pt[0] = quot(mul(db, it.na_y) - mul(da, it.nb_y), r.dir[2]);
                    r.pt[1] = quot(mul(da, it.nb_x) - mul(db, it.na_x), r.dir[2]);
                end
            end
            expected_lines.push_back(r);
        endfunction

        function void check_result(line_res_t got);
            line_res_t e;
            bit        bad;
            if (expected_lines.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result rel=%0d", got.rel);
                end
                return;
            end
            e   = expected_lines.pop_front();
            bad = (e.rel != got.rel);
            for (int i = 0; i < 3; i++)
            begin
                bad |= (e.dir[i] != got.dir[i]) || (e.pt[i] != got.pt[i]);
            end
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch exp rel=%0d dir=%0d,%0d,%0d pt=%0d,%0d,%0d",
                        e.rel, e.dir[0], e.dir[1], e.dir[2], e.pt[0], e.pt[1], e.pt[2]);
                    $display("         got rel=%0d dir=%0d,%0d,%0d pt=%0d,%0d,%0d",
                        got.rel, got.dir[0], got.dir[1], got.dir[2],
                        got.pt[0], got.pt[1], got.pt[2]);
                end
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    in_item_t req;
    logic     out_valid;
    logic     out_ready;
    rel_t     relation;
    coord_t   line_dir_x, line_dir_y, line_dir_z;
    coord_t   line_point_x, line_point_y, line_point_z;
    logic     cfg_wr_en;
    eps_t     cfg_wr_data;

    line_scoreboard sb;
    bit       hold_req;
    bit       hold_done;
    bit       no_idle;
    int       idle_cycles;

    plane_plane_intersection_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .normal_a_x   (req.na_x),
        .normal_a_y   (req.na_y),
        .normal_a_z   (req.na_z),
        .center_a_x   (req.ca_x),
        .center_a_y   (req.ca_y),
        .center_a_z   (req.ca_z),
        .normal_b_x   (req.nb_x),
        .normal_b_y   (req.nb_y),
        .normal_b_z   (req.nb_z),
        .center_b_x   (req.cb_x),
        .center_b_y   (req.cb_y),
        .center_b_z   (req.cb_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .relation     (relation),
        .line_dir_x   (line_dir_x),
        .line_dir_y   (line_dir_y),
        .line_dir_z   (line_dir_z),
        .line_point_x (line_point_x),
        .line_point_y (line_point_y),
        .line_point_z (line_point_z),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 96)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic coord_t rnd_full();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t rnd_small();
        return coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    function automatic coord_t rnd_unit();
        return coord_t'((int'($urandom_range(0, 4)) - 2) <<< FRAC_BITS);
    endfunction

    function automatic in_item_t plane_pair(int kind);
        in_item_t it;
        int       k;
        it = '{default: '0};
        case (kind)
            0:
            begin
                it = {rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                      rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full()};
            end
            1:
            begin
                it = {rnd_small(), rnd_small(), rnd_small(), rnd_small(), rnd_small(),
                      rnd_small(), rnd_small(), rnd_small(), rnd_small(), rnd_small(),
                      rnd_small(), rnd_small()};
            end
            2:
            begin
                // parallel normals, either the same plane or an offset one
                k = int'($urandom_range(0, 6)) - 3;
                it.na_x = rnd_small();
                it.na_y = rnd_small();
                it.na_z = rnd_small();
                it.nb_x = it.na_x * k;
                it.nb_y = it.na_y * k;
                it.nb_z = it.na_z * k;
                it.ca_x = rnd_small();
                it.ca_y = rnd_small();
                it.ca_z = rnd_small();
                it.cb_x = it.ca_x;
                it.cb_y = it.ca_y;
                it.cb_z = it.ca_z;
                if ($urandom_range(0, 1))
                begin
                    it.cb_x = rnd_small();
                end
            end
            default:
            begin
                it = {rnd_unit(), rnd_unit(), rnd_unit(), rnd_small(), rnd_small(), rnd_small(),
                      rnd_unit(), rnd_unit(), rnd_unit(), rnd_small(), rnd_small(), rnd_small()};
            end
        endcase
        return it;
    endfunction

    task automatic send_request(in_item_t it);
        int gap;
        req      <= it;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_request(it);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_eps(eps_t v);
        in_valid <= 1'b0;
        while (sb.expected_lines.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        sb.eps_val = longint'(v);
    endtask

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            send_request(plane_pair(r < 25 ? 0 : r < 65 ? 1 : r < 80 ? 2 : 3));
        end
    endtask

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int hold_cnt;
        int gap_cnt;
        line_res_t got;
        hold_cnt = 0;
        gap_cnt  = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.rel = relation;
                got.dir = '{line_dir_x, line_dir_y, line_dir_z};
                got.pt  = '{line_point_x, line_point_y, line_point_z};
                sb.check_result(got);
            end
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_cnt  = 400;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else if (gap_cnt > 0)
            begin
                gap_cnt--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                gap_cnt = pick_gap();
            end
        end
    end

    // watchdog on cycles with no request or result moving
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= 5000)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        in_item_t it;
        sb          = new();
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req         = '{default: '0};
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        out_ready   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset threshold
        send_request('{default: '0});
        send_request('{default: COORD_MAX});
        send_request('{default: COORD_MIN});
        it = '{default: '0};
        it.na_x = COORD_MAX; it.na_y = COORD_MIN; it.nb_y = COORD_MAX; it.nb_z = COORD_MIN;
        it.ca_x = COORD_MIN; it.cb_z = COORD_MAX;
        send_request(it);
        it = '{default: '0};
        it.na_z = 32'sh10000; it.nb_z = 32'sh20000; it.cb_z = 32'sh30000;
        send_request(it);                       // parallel, offset
        it.cb_z = '0; it.cb_x = 32'sh50000;
        send_request(it);                       // parallel, same plane
        it = '{default: '0};
        it.na_y = 32'sh10000; it.nb_z = 32'sh10000; it.ca_y = 32'sh20000; it.cb_z = 32'sh30000;
        send_request(it);                       // x axis
        it = '{default: '0};
        it.na_x = 32'sh10000; it.nb_z = 32'sh10000; it.ca_x = 32'sh20000; it.cb_z = -32'sh30000;
        send_request(it);                       // y axis
        it = '{default: '0};
        it.na_x = 32'sh10000; it.nb_y = 32'sh10000; it.ca_x = 32'sh18000; it.cb_y = 32'sh7000;
        send_request(it);                       // z axis
        it = '{default: '0};
        it.na_x = 32'sh10000; it.na_y = 32'sh10000; it.nb_z = 32'sh10000; it.cb_z = 32'sh10000;
        send_request(it);                       // tie x/y
        it = '{default: '0};
        it.na_x = 32'sh10000; it.nb_y = 32'sh10000; it.nb_z = 32'sh10000; it.ca_x = 32'sh4000;
        send_request(it);                       // tie y/z
        it = '{default: '0};
        it.na_x = 32'sh10000; it.na_y = -32'sh10000; it.nb_y = 32'sh10000;
        it.nb_z = -32'sh10000; it.ca_y = 32'sh9000;
        send_request(it);                       // three-way tie
        it = '{default: '0};
        it.na_x = 32'sh100; it.nb_y = 32'sh100;
        send_request(it);                       // tiny cross, below threshold
        for (int i = 0; i < 8; i++)
        begin
            send_request(plane_pair(i % 4));
        end

        hold_req = 1'b1;
        random_phase(350);

        write_eps('0);
        send_request('{default: '0});           // zero divisor path
        it = '{default: '0};
        it.na_x = 32'sh10000; it.nb_x = 32'sh10000; it.cb_x = 32'sh10000;
        send_request(it);
        random_phase(250);

        write_eps(eps_t'(31'h7fffffff));
        send_request('{default: COORD_MAX});
        random_phase(250);

        write_eps(eps_t'(32'h10000));
        no_idle = 1'b1;
        random_phase(200);
        no_idle = 1'b0;

        write_eps(eps_t'($urandom));
        random_phase(200);

        write_eps(EPS_RESET);
        random_phase(180);

        in_valid <= 1'b0;
        while (sb.expected_lines.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_lines.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
